FILE: hdl/kdsu_pkg.sv
// Package for the keyed deque: command and status codes, sequencer states.
// No dependencies; used by keyed_deque_search_update.
package kdsu_pkg;

	localparam int CmdW    = 3;
	localparam int StatusW = 2;
	localparam int IdW     = 16;
	localparam int PriceW  = 24;
	localparam int CountW  = 5;

	typedef enum logic [CmdW-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_SEARCH     = 3'd4,
		CMD_UPDATE     = 3'd5,
		CMD_COUNT      = 3'd6,
		CMD_MAX        = 3'd7
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_RESULT
	} state_t;

endpackage

FILE: hdl/keyed_deque_search_update.sv
// Bounded double-ended queue of (id, price) entries in a ring memory.
// One shared slot adder and one memory read port walk the entries.
// Depends on kdsu_pkg.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------
//  in      | in_valid, in_ready, cmd, item_id,         | one command per item
//          | item_price                                |
//  out     | out_valid, out_ready, status, result_id,  | one result per item
//          | result_price, item_count                  |
//
// Push and count go straight to the result state; pop first takes the entry
// in the pop state. Search, update and maximum walk the ring one entry per
// cycle through the memory read port; a search or update stops at a hit.
// Reset clears the pointers and occupancy; entry memory is not cleared.
// One item at a time: in_ready is low from acceptance until the result is
// loaded into the output register, which holds while out_ready is low.
module keyed_deque_search_update #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kdsu_pkg::CmdW-1:0]     cmd,
	input  logic [kdsu_pkg::IdW-1:0]      item_id,
	input  logic [kdsu_pkg::PriceW-1:0]   item_price,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kdsu_pkg::StatusW-1:0]  status,
	output logic [kdsu_pkg::IdW-1:0]      result_id,
	output logic [kdsu_pkg::PriceW-1:0]   result_price,
	output logic [kdsu_pkg::CountW-1:0]   item_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CapS   = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CapC   = CW'(CAPACITY);
	localparam logic [AW-1:0] LastSl = AW'(CAPACITY - 1);

	kdsu_pkg::state_t state_q, state_d;
	kdsu_pkg::cmd_t   cmd_q, cmd_in;

	logic [AW-1:0] front_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] idx_q;
	logic          rvalid_q;
	logic [AW-1:0] cmp_slot_q;
	logic          best_v_q;

	logic [kdsu_pkg::IdW-1:0]    id_q;
	logic [kdsu_pkg::PriceW-1:0] price_q;

	kdsu_pkg::status_t           res_status_q;
	logic [kdsu_pkg::IdW-1:0]    res_id_q;
	logic [kdsu_pkg::PriceW-1:0] res_price_q;

	logic [kdsu_pkg::IdW-1:0]    mem_id    [CAPACITY];
	logic [kdsu_pkg::PriceW-1:0] mem_price [CAPACITY];
	logic [kdsu_pkg::IdW-1:0]    rd_id_q;
	logic [kdsu_pkg::PriceW-1:0] rd_price_q;

	logic          accept;
	logic          full, empty;
	logic          out_free;
	logic [CW-1:0] off;
	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic          issue;
	logic          hit;
	logic          scan_done;
	logic          we_id, we_price;
	logic [AW-1:0] waddr;
	logic [kdsu_pkg::PriceW-1:0] wprice;

	assign cmd_in   = kdsu_pkg::cmd_t'(cmd);
	assign full     = (occ_q == CapC);
	assign empty    = (occ_q == '0);
	assign out_free = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	assign front_dec = (front_q == '0) ? LastSl : front_q - 1'b1;
	assign front_inc = (front_q == LastSl) ? '0 : front_q + 1'b1;

	// shared slot unit: front plus offset, modulo capacity
	assign slot_sum = (AW+1)'(front_q) + (AW+1)'(off);
	assign slot     = (slot_sum >= CapS) ? AW'(slot_sum - CapS) : AW'(slot_sum);

	assign issue     = (state_q == kdsu_pkg::ST_SCAN) && (idx_q < occ_q);
	assign hit       = rvalid_q && (rd_id_q == id_q) &&
	                   (cmd_q == kdsu_pkg::CMD_SEARCH || cmd_q == kdsu_pkg::CMD_UPDATE);
	assign scan_done = !rvalid_q && !issue;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kdsu_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd_in)
						kdsu_pkg::CMD_POP_FRONT,
						kdsu_pkg::CMD_POP_BACK:
							state_d = empty ? kdsu_pkg::ST_RESULT : kdsu_pkg::ST_POP;
						kdsu_pkg::CMD_SEARCH,
						kdsu_pkg::CMD_UPDATE:
							state_d = kdsu_pkg::ST_SCAN;
						kdsu_pkg::CMD_MAX:
							state_d = empty ? kdsu_pkg::ST_RESULT : kdsu_pkg::ST_SCAN;
						default:
							state_d = kdsu_pkg::ST_RESULT;
					endcase
				end
			end
			kdsu_pkg::ST_POP:  state_d = kdsu_pkg::ST_RESULT;
			kdsu_pkg::ST_SCAN: begin
				if (hit || scan_done)
					state_d = kdsu_pkg::ST_RESULT;
			end
			kdsu_pkg::ST_RESULT: begin
				if (out_free)
					state_d = kdsu_pkg::ST_IDLE;
			end
			default: state_d = kdsu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == kdsu_pkg::ST_IDLE);
		off      = '0;
		we_id    = 1'b0;
		we_price = 1'b0;
		waddr    = slot;
		wprice   = item_price;
		unique case (state_q)
			kdsu_pkg::ST_IDLE: begin
				unique case (cmd_in)
					kdsu_pkg::CMD_PUSH_BACK: off = occ_q;
					kdsu_pkg::CMD_POP_BACK:  off = occ_q - 1'b1;
					default:                 off = '0;
				endcase
				if (accept && !full &&
				    (cmd_in == kdsu_pkg::CMD_PUSH_BACK ||
				     cmd_in == kdsu_pkg::CMD_PUSH_FRONT)) begin
					we_id    = 1'b1;
					we_price = 1'b1;
					waddr    = (cmd_in == kdsu_pkg::CMD_PUSH_FRONT) ? front_dec : slot;
				end
			end
			kdsu_pkg::ST_SCAN: begin
				off = idx_q;
				if (hit && cmd_q == kdsu_pkg::CMD_UPDATE) begin
					we_price = 1'b1;
					waddr    = cmp_slot_q;
					wprice   = price_q;
				end
			end
			default: off = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_id)
			mem_id[waddr] <= item_id;
		if (we_price)
			mem_price[waddr] <= wprice;
		rd_id_q    <= mem_id[slot];
		rd_price_q <= mem_price[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kdsu_pkg::ST_IDLE;
			front_q   <= '0;
			occ_q     <= '0;
			idx_q     <= '0;
			rvalid_q  <= 1'b0;
			out_valid <= 1'b0;
			cmd_q     <= kdsu_pkg::CMD_COUNT;
		end else begin
			state_q <= state_d;
			if (state_q == kdsu_pkg::ST_RESULT && out_free)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				kdsu_pkg::ST_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd_in;
						idx_q    <= '0;
						rvalid_q <= 1'b0;
						unique case (cmd_in)
							kdsu_pkg::CMD_PUSH_BACK: begin
								if (!full)
									occ_q <= occ_q + 1'b1;
							end
							kdsu_pkg::CMD_PUSH_FRONT: begin
								if (!full) begin
									occ_q   <= occ_q + 1'b1;
									front_q <= front_dec;
								end
							end
							kdsu_pkg::CMD_POP_FRONT: begin
								if (!empty) begin
									occ_q   <= occ_q - 1'b1;
									front_q <= front_inc;
								end
							end
							kdsu_pkg::CMD_POP_BACK: begin
								if (!empty)
									occ_q <= occ_q - 1'b1;
							end
							default: ;
						endcase
					end
				end
				kdsu_pkg::ST_SCAN: begin
					rvalid_q <= issue;
					if (issue)
						idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			kdsu_pkg::ST_IDLE: begin
				if (accept) begin
					id_q        <= item_id;
					price_q     <= item_price;
					res_id_q    <= '0;
					res_price_q <= '0;
					best_v_q    <= 1'b0;
					unique case (cmd_in)
						kdsu_pkg::CMD_PUSH_BACK,
						kdsu_pkg::CMD_PUSH_FRONT:
							res_status_q <= full ? kdsu_pkg::STATUS_FULL : kdsu_pkg::STATUS_OK;
						kdsu_pkg::CMD_POP_FRONT,
						kdsu_pkg::CMD_POP_BACK,
						kdsu_pkg::CMD_MAX:
							res_status_q <= empty ? kdsu_pkg::STATUS_EMPTY : kdsu_pkg::STATUS_OK;
						default:
							res_status_q <= kdsu_pkg::STATUS_OK;
					endcase
				end
			end
			kdsu_pkg::ST_POP: begin
				res_id_q    <= rd_id_q;
				res_price_q <= rd_price_q;
			end
			kdsu_pkg::ST_SCAN: begin
				cmp_slot_q <= slot;
				if (cmd_q == kdsu_pkg::CMD_MAX) begin
					if (rvalid_q && (!best_v_q || rd_price_q > res_price_q)) begin
						res_id_q    <= rd_id_q;
						res_price_q <= rd_price_q;
					end
					if (rvalid_q)
						best_v_q <= 1'b1;
				end else if (hit) begin
					res_status_q <= kdsu_pkg::STATUS_OK;
					res_id_q     <= rd_id_q;
					res_price_q  <= (cmd_q == kdsu_pkg::CMD_UPDATE) ? price_q : rd_price_q;
				end else if (scan_done) begin
					res_status_q <= kdsu_pkg::STATUS_NOT_FOUND;
				end
			end
			kdsu_pkg::ST_RESULT: begin
				if (out_free) begin
					status       <= res_status_q;
					result_id    <= res_id_q;
					result_price <= res_price_q;
					item_count   <= kdsu_pkg::CountW'(occ_q);
				end
			end
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready stayed high after an item was taken");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CapC)
		else $error("occupancy beyond capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full &&
		(cmd_in == kdsu_pkg::CMD_PUSH_BACK || cmd_in == kdsu_pkg::CMD_PUSH_FRONT)
		|=> occ_q == $past(occ_q) + 1'b1)
		else $error("push did not grow the queue");

	a_load_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == kdsu_pkg::ST_RESULT))
		else $error("result loaded outside the result state");

	a_no_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we_id |-> state_q == kdsu_pkg::ST_IDLE && !full)
		else $error("entry id written outside a push");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for keyed_deque_search_update: directed, back-pressure and random tests.
// A behavioural deque with the same capacity predicts every result; a checker compares them.
// Depends on kdsu_pkg and keyed_deque_search_update.
module tb_top;

	localparam int CAP         = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 80;

	typedef struct packed {
		kdsu_pkg::status_t                 status;
		logic [kdsu_pkg::IdW-1:0]          id;
		logic [kdsu_pkg::PriceW-1:0]       price;
		logic [kdsu_pkg::CountW-1:0]       count;
	} answer_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic [kdsu_pkg::CmdW-1:0]           cmd;
	logic [kdsu_pkg::IdW-1:0]            item_id;
	logic [kdsu_pkg::PriceW-1:0]         item_price;
	logic                                out_valid;
	logic                                out_ready;
	logic [kdsu_pkg::StatusW-1:0]        status;
	logic [kdsu_pkg::IdW-1:0]            result_id;
	logic [kdsu_pkg::PriceW-1:0]         result_price;
	logic [kdsu_pkg::CountW-1:0]         item_count;

	logic [kdsu_pkg::IdW-1:0]            shelf_id [CAP];
	logic [kdsu_pkg::PriceW-1:0]         shelf_price [CAP];
	int                                  head;
	int                                  fill;
	int                                  peak_fill;

	answer_t                             pending_answers [$];
	answer_t                             due;
	logic [kdsu_pkg::IdW-1:0]            key_pool [6];

	int                  items_sent;
	int                  results_seen;
	int                  fail_count;
	int                  full_seen;
	int                  empty_seen;
	int                  miss_seen;
	int                  hold_request;
	int unsigned         cycle_count;
	bit                  source_idle_on;
	bit                  sink_idle_on;

	keyed_deque_search_update #(.CAPACITY(CAP)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.item_id      (item_id),
		.item_price   (item_price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_id    (result_id),
		.result_price (result_price),
		.item_count   (item_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				pending_answers.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic answer_t apply_command(kdsu_pkg::cmd_t op,
		logic [kdsu_pkg::IdW-1:0] id, logic [kdsu_pkg::PriceW-1:0] price);
		answer_t a;
		int slot;
		int hit;
		a.status = kdsu_pkg::STATUS_OK;
		a.id     = '0;
		a.price  = '0;
		case (op)
			kdsu_pkg::CMD_PUSH_BACK, kdsu_pkg::CMD_PUSH_FRONT: begin
				if (fill == CAP) begin
					a.status = kdsu_pkg::STATUS_FULL;
				end else begin
					if (op == kdsu_pkg::CMD_PUSH_BACK) begin
						slot = (head + fill) % CAP;
					end else begin
						head = (head + CAP - 1) % CAP;
						slot = head;
					end
					shelf_id[slot]    = id;
					shelf_price[slot] = price;
					fill++;
					if (fill > peak_fill)
						peak_fill = fill;
				end
			end
			kdsu_pkg::CMD_POP_FRONT, kdsu_pkg::CMD_POP_BACK: begin
				if (fill == 0) begin
					a.status = kdsu_pkg::STATUS_EMPTY;
				end else begin
					slot    = (op == kdsu_pkg::CMD_POP_FRONT) ? head : (head + fill - 1) % CAP;
					a.id    = shelf_id[slot];
					a.price = shelf_price[slot];
					if (op == kdsu_pkg::CMD_POP_FRONT)
						head = (head + 1) % CAP;
					fill--;
				end
			end
			kdsu_pkg::CMD_SEARCH, kdsu_pkg::CMD_UPDATE: begin
				hit = -1;
				for (int k = 0; k < fill; k++)
					if (hit < 0 && shelf_id[(head + k) % CAP] == id)
						hit = (head + k) % CAP;
				if (hit < 0) begin
					a.status = kdsu_pkg::STATUS_NOT_FOUND;
				end else begin
					if (op == kdsu_pkg::CMD_UPDATE)
						shelf_price[hit] = price;
					a.id    = shelf_id[hit];
					a.price = shelf_price[hit];
				end
			end
			kdsu_pkg::CMD_COUNT: begin
			end
			default: begin
				if (fill == 0) begin
					a.status = kdsu_pkg::STATUS_EMPTY;
				end else begin
					slot = head;
					for (int k = 1; k < fill; k++)
						if (shelf_price[(head + k) % CAP] > shelf_price[slot])
							slot = (head + k) % CAP;
					a.id    = shelf_id[slot];
					a.price = shelf_price[slot];
				end
			end
		endcase
		a.count = kdsu_pkg::CountW'(fill);
		return a;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result %0d with nothing pending: status %0d id %h price %h count %0d",
						results_seen, status, result_id, result_price, item_count);
			end else begin
				due = pending_answers.pop_front();
				case (due.status)
					kdsu_pkg::STATUS_FULL:      full_seen++;
					kdsu_pkg::STATUS_EMPTY:     empty_seen++;
					kdsu_pkg::STATUS_NOT_FOUND: miss_seen++;
					default: ;
				endcase
				if (status !== due.status || result_id !== due.id ||
					result_price !== due.price || item_count !== due.count) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result %0d mismatch: expected status %0d id %h price %h count %0d",
							results_seen, due.status, due.id, due.price, due.count);
						$display("    got status %0d id %h price %h count %0d",
							status, result_id, result_price, item_count);
					end
				end
			end
		end
	end

	initial begin : sink
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request - 1;
				hold_request = 0;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(kdsu_pkg::cmd_t op, logic [kdsu_pkg::IdW-1:0] id,
		logic [kdsu_pkg::PriceW-1:0] price);
		int gap;
		in_valid   <= 1'b1;
		cmd        <= op;
		item_id    <= id;
		item_price <= price;
		do @(posedge clk); while (!in_ready);
		pending_answers.push_back(apply_command(op, id, price));
		items_sent++;
		if (source_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	function automatic logic [kdsu_pkg::IdW-1:0] pick_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, 5)];
		return kdsu_pkg::IdW'($urandom);
	endfunction

	function automatic logic [kdsu_pkg::PriceW-1:0] pick_price();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return kdsu_pkg::PriceW'($urandom);
		if (r < 8)
			return kdsu_pkg::PriceW'($urandom_range(0, 7));
		return r[0] ? '1 : '0;
	endfunction

	task automatic test_empty_queue();
		send_item(kdsu_pkg::CMD_POP_FRONT, '0, '0);
		send_item(kdsu_pkg::CMD_POP_BACK, '1, '1);
		send_item(kdsu_pkg::CMD_MAX, '0, '0);
		send_item(kdsu_pkg::CMD_SEARCH, '1, '0);
		send_item(kdsu_pkg::CMD_UPDATE, '0, '1);
		send_item(kdsu_pkg::CMD_COUNT, '0, '0);
		wait_all_results();
	endtask

	task automatic test_field_extremes();
		send_item(kdsu_pkg::CMD_PUSH_BACK, '0, '0);
		send_item(kdsu_pkg::CMD_PUSH_FRONT, '1, '1);
		send_item(kdsu_pkg::CMD_PUSH_BACK, 16'h5a5a, '1);
		send_item(kdsu_pkg::CMD_PUSH_FRONT, '0, 24'h000001);
		send_item(kdsu_pkg::CMD_MAX, '0, '0);
		send_item(kdsu_pkg::CMD_SEARCH, '0, '0);
		send_item(kdsu_pkg::CMD_UPDATE, '0, 24'ha5a5a5);
		send_item(kdsu_pkg::CMD_SEARCH, 16'h5a5a, '0);
		send_item(kdsu_pkg::CMD_SEARCH, 16'h1234, '0);
		send_item(kdsu_pkg::CMD_UPDATE, 16'h1234, '1);
		send_item(kdsu_pkg::CMD_COUNT, '0, '0);
		send_item(kdsu_pkg::CMD_POP_BACK, '0, '0);
		send_item(kdsu_pkg::CMD_POP_FRONT, '0, '0);
		send_item(kdsu_pkg::CMD_POP_FRONT, '0, '0);
		send_item(kdsu_pkg::CMD_POP_BACK, '0, '0);
		send_item(kdsu_pkg::CMD_POP_BACK, '0, '0);
		send_item(kdsu_pkg::CMD_MAX, '0, '0);
		wait_all_results();
	endtask

	task automatic test_backpressure_fill();
		source_idle_on = 1'b0;
		sink_idle_on   = 1'b1;
		hold_request   = LONG_HOLD;
		repeat (CAP + 3)
			send_item($urandom_range(0, 1) ? kdsu_pkg::CMD_PUSH_BACK : kdsu_pkg::CMD_PUSH_FRONT,
				kdsu_pkg::IdW'($urandom), pick_price());
		send_item(kdsu_pkg::CMD_MAX, '0, '0);
		send_item(kdsu_pkg::CMD_COUNT, '0, '0);
		repeat (CAP + 1)
			send_item($urandom_range(0, 1) ? kdsu_pkg::CMD_POP_FRONT : kdsu_pkg::CMD_POP_BACK,
				'0, '0);
		wait_all_results();
	endtask

	task automatic test_random_mix(int n, bit idle);
		bit grow;
		int r;
		int push_pct;
		int pop_pct;
		kdsu_pkg::cmd_t op;
		source_idle_on = idle;
		sink_idle_on   = idle;
		grow = 1'b1;
		foreach (key_pool[i])
			key_pool[i] = kdsu_pkg::IdW'($urandom);
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0 && $urandom_range(0, 2) != 0)
				grow = ~grow;
			push_pct = grow ? 55 : 15;
			pop_pct  = grow ? 15 : 55;
			r = $urandom_range(0, 99);
			if (r < push_pct)
				op = $urandom_range(0, 1) ? kdsu_pkg::CMD_PUSH_BACK : kdsu_pkg::CMD_PUSH_FRONT;
			else if (r < push_pct + pop_pct)
				op = $urandom_range(0, 1) ? kdsu_pkg::CMD_POP_FRONT : kdsu_pkg::CMD_POP_BACK;
			else if (r < push_pct + pop_pct + 20)
				op = $urandom_range(0, 1) ? kdsu_pkg::CMD_SEARCH : kdsu_pkg::CMD_UPDATE;
			else if (r < push_pct + pop_pct + 23)
				op = kdsu_pkg::CMD_COUNT;
			else
				op = kdsu_pkg::CMD_MAX;
			send_item(op, pick_key(), pick_price());
			if (idle && $urandom_range(0, 99) == 0)
				wait_all_results();
		end
		wait_all_results();
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		cmd        <= kdsu_pkg::CMD_COUNT;
		item_id    <= '0;
		item_price <= '0;
		head = 0;
		fill = 0;
		peak_fill = 0;
		hold_request = 0;
		source_idle_on = 1'b1;
		sink_idle_on   = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_field_extremes();
		test_backpressure_fill();
		test_random_mix(640, 1'b1);
		test_random_mix(150, 1'b0);

		wait_all_results();
		repeat (CAP + 8) @(posedge clk);
		if (pending_answers.size() != 0)
			fail_count++;
		$display("Covered %0d items and %0d results over %0d cycles, peak depth %0d of %0d",
			items_sent, results_seen, cycle_count, peak_fill, CAP);
		$display("Status mix: %0d full, %0d empty, %0d not found; %0d failures",
			full_seen, empty_seen, miss_seen, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/kdsu_pkg.sv
hdl/keyed_deque_search_update.sv
bench/tb_top.sv
